// File: rtl/kinsoku_line_wrapper_defines.svh
// Assertion macros shared by the checker of kinsoku_line_wrapper.
// No dependencies; included by klw_checker.sv.
`ifndef KINSOKU_LINE_WRAPPER_DEFINES_SVH
`define KINSOKU_LINE_WRAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define KLW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define KLW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/klw_pkg.sv
// Shared types, constants and glyph helper functions for kinsoku_line_wrapper.
// No dependencies; used by every module of the block.
package klw_pkg;

    localparam int CELL_W         = 8;
    localparam int MAX_WRAP_CELLS = 255;
    localparam int FORBIDDEN_CNT  = 25;

    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [23:0] IDEO_SPACE   = 24'hE38080;

    localparam logic [CELL_W-1:0] WRAP_RESET = CELL_W'(40);

    typedef enum logic [1:0] {
        CFG_WRAP_WIDTH = 2'd0,
        CFG_RUBY_OPEN  = 2'd1,
        CFG_RUBY_SPLIT = 2'd2,
        CFG_RUBY_CLOSE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       text_end;
    } t_klw_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_out;
        logic       run_last;
        logic       text_done;
    } t_klw_out;

    // One accepted byte's worth of results: optional line end, up to four
    // text bytes, optional trailing line end.
    typedef struct packed {
        logic            pre_end;
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            post_end;
        logic            text_end;
    } t_klw_desc;

    localparam logic [23:0] FORBIDDEN_START [FORBIDDEN_CNT] = '{
        24'hE38082, 24'hE38081, 24'hEFBC8C, 24'hEFBC8E, 24'hE383BB, 24'hE280A6,
        24'hE383BC, 24'hEFBC9A, 24'hEFBC9B, 24'hEFBC9F, 24'hEFBC81, 24'hEFBCBD,
        24'hE2809D, 24'hE38080, 24'hEFBC89, 24'hE3808D, 24'hE3808F,
        24'hEE8080, 24'hEE8081, 24'hEE8082, 24'hEE8083,
        24'hEE8084, 24'hEE8085, 24'hEE8086, 24'hEE8087
    };

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'h80) begin
            n = 3'd1;
        end else if (b < 8'hE0) begin
            n = 3'd2;
        end else if (b < 8'hF0) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [23:0] pack3(input logic [3:0][7:0] g);
        return {g[0], g[1], g[2]};
    endfunction

    function automatic logic [1:0] display_cells(input logic [3:0][7:0] g,
                                                 input logic [2:0] n);
        logic [1:0] c;
        if (n == 3'd0) begin
            c = 2'd0;
        end else if (g[0] < 8'h80) begin
            c = 2'd1;
        end else if (n == 3'd3 && g[0] == 8'hEF &&
                     ((g[1] == 8'hBD && g[2] >= 8'hA1) ||
                      (g[1] == 8'hBE && g[2] <= 8'h9F))) begin
            // half-width katakana
            c = 2'd1;
        end else begin
            c = 2'd2;
        end
        return c;
    endfunction

    function automatic logic is_forbidden(input logic [3:0][7:0] g,
                                          input logic [2:0] n);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < FORBIDDEN_CNT; i++) begin
            if (pack3(g) == FORBIDDEN_START[i]) begin
                hit = 1'b1;
            end
        end
        return hit && (n == 3'd3);
    endfunction

    function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] cells,
                                                  input logic [1:0] c);
        logic [CELL_W:0] s;
        s = {1'b0, cells} + {{(CELL_W-1){1'b0}}, c};
        if (s > (CELL_W+1)'(MAX_WRAP_CELLS)) begin
            s = (CELL_W+1)'(MAX_WRAP_CELLS);
        end
        return s[CELL_W-1:0];
    endfunction

endpackage

// File: rtl/kinsoku_line_wrapper.sv
// Top level of the kinsoku line wrapper: front end, descriptor queue, back end.
// Depends on klw_pkg, klw_front, klw_queue and klw_back.
//
//   channel  direction  handshake                payload
//   in       sink       i_in_valid/o_in_ready    t_klw_in  (byte_in, text_end)
//   out      source     o_out_valid/i_out_ready  t_klw_out (kind, byte_out, ...)
//   cfg      sink       i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// The front end takes one byte per cycle while the queue has room and resolves
// it in that cycle. The back end sends one result per cycle while the output
// is not stalled; a glyph of n bytes with a break gives up to n + 2 results.
// A result passes through a queue entry and the back-end output register.
// Synchronous active-low reset clears all control state; configuration
// returns to width 40 with ruby handling off. Configuration is always ready.
// Output stalls back up through the two-entry queue into o_in_ready.
module kinsoku_line_wrapper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  klw_pkg::t_klw_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output klw_pkg::t_klw_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    logic               push_valid, push_ready, head_valid, pop;
    klw_pkg::t_klw_desc push_data, head;

    klw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    klw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (head_valid),
        .i_pop        (pop),
        .o_pop_data   (head)
    );

    klw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// File: rtl/klw_front.sv
// Front end: configuration registers, glyph gathering, cell counting and
// line-break decisions; emits a result descriptor per byte with results. Uses klw_pkg.
module klw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  klw_pkg::t_klw_in   i_in_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output klw_pkg::t_klw_desc o_push_data
);

    logic [klw_pkg::CELL_W-1:0] r_wrap;
    logic [7:0]                 r_ropen, r_rsplit, r_rclose;

    logic [3:0][7:0]            r_buf, n_buf;
    logic [2:0]                 r_fill, n_fill;
    logic [2:0]                 r_len, n_len;
    logic [klw_pkg::CELL_W-1:0] r_cells, n_cells;
    logic r_pend, n_pend, r_hang, n_hang, r_jw, n_jw;
    logic r_rbase, n_rbase, r_rread, n_rread, r_nonempty, n_nonempty;
    logic r_anyle, n_anyle;

    logic [7:0] b;
    logic       text_end, accept;
    logic       pre, post, single, do_flush, do_fin, thr;
    logic [2:0] nb;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_push_ready;
    assign accept      = i_in_valid && i_push_ready;
    assign b           = i_in_data.byte_in;
    assign text_end    = i_in_data.text_end;

    always_comb begin
        n_buf      = r_buf;
        n_fill     = r_fill;
        n_len      = r_len;
        n_cells    = r_cells;
        n_pend     = r_pend;
        n_hang     = r_hang;
        n_jw       = r_jw;
        n_rbase    = r_rbase;
        n_rread    = r_rread;
        n_nonempty = r_nonempty;
        n_anyle    = r_anyle;
        pre        = 1'b0;
        post       = 1'b0;
        single     = 1'b0;
        do_flush   = 1'b0;
        do_fin     = 1'b0;
        thr        = 1'b0;
        nb         = 3'd0;

        if (r_rbase) begin
            single = 1'b1;
            if (b == r_rclose) begin
                do_flush = 1'b1;
                n_rbase  = 1'b0;
                thr      = 1'b1;
            end else if (b == r_rsplit) begin
                do_flush = 1'b1;
                n_rbase  = 1'b0;
                n_rread  = 1'b1;
            end else begin
                if (r_fill == 3'd0) begin
                    n_len = klw_pkg::lead_length(b);
                end
                n_buf[r_fill[1:0]] = b;
                n_fill             = r_fill + 3'd1;
                if (n_fill >= n_len) begin
                    do_flush = 1'b1;
                end
            end
        end else if (r_rread) begin
            single = 1'b1;
            if (b == r_rclose) begin
                n_rread = 1'b0;
                thr     = 1'b1;
            end
        end else if (r_fill == 3'd0 && b == klw_pkg::NEWLINE_BYTE) begin
            // a newline is never a forbidden start, so a pending decision wraps
            if (r_pend) begin
                n_pend = 1'b0;
                pre    = 1'b1;
                n_jw   = 1'b1;
            end
            if (!n_jw) begin
                pre = 1'b1;
            end
            n_anyle    = r_anyle | pre;
            n_cells    = '0;
            n_hang     = 1'b0;
            n_jw       = 1'b0;
            n_nonempty = 1'b0;
        end else if (r_fill == 3'd0 && r_ropen != 8'd0 && b == r_ropen) begin
            if (r_pend) begin
                n_pend  = 1'b0;
                pre     = 1'b1;
                n_anyle = 1'b1;
                n_hang  = 1'b0;
            end
            single     = 1'b1;
            n_cells    = pre ? '0 : r_cells;
            n_rbase    = 1'b1;
            n_jw       = 1'b0;
            n_nonempty = 1'b1;
        end else begin
            if (r_fill == 3'd0) begin
                n_len = klw_pkg::lead_length(b);
            end
            n_buf[r_fill[1:0]] = b;
            n_fill             = r_fill + 3'd1;
            if (n_fill >= n_len) begin
                do_fin = 1'b1;
            end
        end

        // end of text closes an open base glyph or a partial glyph
        if (text_end && n_rbase) begin
            do_flush = 1'b1;
        end
        if (text_end && !n_rbase && !n_rread && !do_flush && n_fill != 3'd0) begin
            do_fin = 1'b1;
        end

        if (do_flush) begin
            if (n_fill != 3'd0) begin
                n_cells = klw_pkg::sat_add(n_cells, klw_pkg::display_cells(n_buf, n_fill));
            end
            n_fill = 3'd0;
        end
        if (thr && ({1'b0, n_cells} + 9'd1 >= {1'b0, r_wrap})) begin
            n_pend = 1'b1;
        end

        if (do_fin) begin
            if (n_pend) begin
                n_pend = 1'b0;
                if (n_hang) begin
                    if (!(n_fill == 3'd3 && klw_pkg::pack3(n_buf) == klw_pkg::IDEO_SPACE)) begin
                        pre = 1'b1;
                    end
                end else if (klw_pkg::is_forbidden(n_buf, n_fill)) begin
                    n_hang = 1'b1;
                end else begin
                    pre = 1'b1;
                end
                if (pre) begin
                    n_anyle    = 1'b1;
                    n_cells    = '0;
                    n_hang     = 1'b0;
                end
            end
            nb         = n_fill;
            n_cells    = klw_pkg::sat_add(n_cells, klw_pkg::display_cells(n_buf, n_fill));
            n_jw       = 1'b0;
            n_nonempty = 1'b1;
            n_fill     = 3'd0;
            if ({1'b0, n_cells} + 9'd1 >= {1'b0, r_wrap}) begin
                n_pend = 1'b1;
            end
        end

        if (single) begin
            nb = 3'd1;
        end

        if (text_end) begin
            post       = n_nonempty || !n_anyle;
            n_fill     = 3'd0;
            n_len      = 3'd0;
            n_cells    = '0;
            n_pend     = 1'b0;
            n_hang     = 1'b0;
            n_jw       = 1'b0;
            n_rbase    = 1'b0;
            n_rread    = 1'b0;
            n_nonempty = 1'b0;
            n_anyle    = 1'b0;
        end
    end

    always_comb begin
        o_push_data.pre_end  = pre;
        o_push_data.nbytes   = nb;
        o_push_data.bytes    = single ? {24'd0, b} : n_buf;
        o_push_data.post_end = post;
        o_push_data.text_end = text_end;
        o_push_valid         = i_in_valid && (pre || post || nb != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap     <= klw_pkg::WRAP_RESET;
            r_ropen    <= '0;
            r_rsplit   <= '0;
            r_rclose   <= '0;
            r_fill     <= '0;
            r_len      <= '0;
            r_cells    <= '0;
            r_pend     <= 1'b0;
            r_hang     <= 1'b0;
            r_jw       <= 1'b0;
            r_rbase    <= 1'b0;
            r_rread    <= 1'b0;
            r_nonempty <= 1'b0;
            r_anyle    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (klw_pkg::t_cfg_index'(i_cfg_index))
                    klw_pkg::CFG_WRAP_WIDTH: r_wrap   <= i_cfg_data;
                    klw_pkg::CFG_RUBY_OPEN:  r_ropen  <= i_cfg_data;
                    klw_pkg::CFG_RUBY_SPLIT: r_rsplit <= i_cfg_data;
                    klw_pkg::CFG_RUBY_CLOSE: r_rclose <= i_cfg_data;
                    default:                 r_wrap   <= r_wrap;
                endcase
            end
            if (accept) begin
                r_fill     <= n_fill;
                r_len      <= n_len;
                r_cells    <= n_cells;
                r_pend     <= n_pend;
                r_hang     <= n_hang;
                r_jw       <= n_jw;
                r_rbase    <= n_rbase;
                r_rread    <= n_rread;
                r_nonempty <= n_nonempty;
                r_anyle    <= n_anyle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end
    end

endmodule

// File: rtl/klw_queue.sv
// Two-entry descriptor queue between front and back ends.
// Uses klw_pkg for the descriptor type.
module klw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  klw_pkg::t_klw_desc i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop,
    output klw_pkg::t_klw_desc o_pop_data
);

    klw_pkg::t_klw_desc r_mem [2];
    logic               r_wr_ptr, r_rd_ptr;
    logic [1:0]         r_count;
    logic               push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/klw_back.sv
// Back end: walks the head descriptor one result per cycle, while the output
// is not stalled, into the output register. Uses klw_pkg for descriptor and result types.
module klw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  klw_pkg::t_klw_desc i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output klw_pkg::t_klw_out  o_out_data
);

    logic [2:0]        r_idx;
    logic              r_valid;
    klw_pkg::t_klw_out r_data, n_data;
    logic [2:0]        total, j;
    logic              load, last, is_end;

    assign total  = {2'd0, i_head.pre_end} + i_head.nbytes + {2'd0, i_head.post_end};
    assign j      = r_idx - {2'd0, i_head.pre_end};
    assign last   = (r_idx == total - 3'd1);
    assign is_end = (i_head.pre_end && r_idx == 3'd0) || (j >= i_head.nbytes);
    assign load   = i_head_valid && (!r_valid || i_out_ready);
    assign o_pop  = load && last;

    always_comb begin
        n_data.kind      = is_end;
        n_data.byte_out  = is_end ? 8'd0 : i_head.bytes[j[1:0]];
        n_data.run_last  = last;
        n_data.text_done = last && i_head.text_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= last ? 3'd0 : r_idx + 3'd1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// File: rtl/klw_checker.sv
// Port-level checks for kinsoku_line_wrapper, bound to the top level.
// Depends on klw_pkg and kinsoku_line_wrapper_defines.svh.
`include "kinsoku_line_wrapper_defines.svh"

module klw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input klw_pkg::t_klw_out o_out_data
);

    `KLW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")
    `KLW_ASSERT_SAME(a_done_last, i_clk, i_rst_n, o_out_valid && o_out_data.text_done, o_out_data.run_last, "text_done without run_last")
    `KLW_ASSERT_SAME(a_end_zero, i_clk, i_rst_n, o_out_valid && o_out_data.kind, o_out_data.byte_out == 8'd0, "line end with nonzero byte")

endmodule

bind kinsoku_line_wrapper klw_checker u_klw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
